@@ src/sfrc_pkg.sv @@
// Shared constants and types of the serial frame receiver.
package sfrc_pkg;

   localparam int unsigned FRAME_BYTES_DEF = 16;
   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned POS_W           = 4;
   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hFF;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_SUM  = 2'd1,
      KIND_LEN  = 2'd2
   } kind_type;

endpackage

@@ src/sfrc_req_if.sv @@
// Receive byte channel: valid/ready with one serial byte per beat.
interface sfrc_req_if;
   import sfrc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ src/sfrc_rsp_if.sv @@
// Result channel: valid/ready with frame bytes and error reports.
interface sfrc_rsp_if;
   import sfrc_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [BYTE_W-1:0] frame_data;
   logic [POS_W-1:0]  position;
   logic              last_of_run;

   modport source (output valid, output kind, output frame_data, output position,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input frame_data, input position,
                   input last_of_run, output ready);
endinterface

@@ src/sfrc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sfrc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/serial_frame_receiver_checksum.sv @@
// Serial frame receiver: header hunt, frame store, inverted-sum check, readout.
//
//   channel  | dir | beat contents
//   ---------+-----+-----------------------------------------------
//   req_ch   | in  | rx_byte
//   rsp_ch   | out | kind, frame_data, position, last_of_run
//   csr      | in  | header_byte write (csr_wr_en, csr_wr_data)
//
// A received byte is taken while idle and the result register is free or draining.
// A good frame is read back from the frame store through its single read port,
// with registered read data, then one result per cycle (length+2 results) at
// full sink rate; receive beats are held off during the readout.
// Reset is synchronous; the frame store needs no clearing since every entry
// read is written earlier in the same frame. Results wait in one output register.
module serial_frame_receiver_checksum #(
   parameter int unsigned FRAME_BYTES = sfrc_pkg::FRAME_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   sfrc_req_if.sink                    req_ch,
   sfrc_rsp_if.source                  rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [sfrc_pkg::BYTE_W-1:0] csr_wr_data
);
   import sfrc_pkg::*;

   localparam int unsigned IDX_W = $clog2(FRAME_BYTES);
   localparam logic [BYTE_W:0] MAX_LEN = (BYTE_W+1)'(FRAME_BYTES - 5);

   typedef enum logic [0:0] {S_IDLE, S_LOAD} state_type;

   state_type         state_ff, state_in;
   logic              in_frame_ff, in_frame_in;
   logic [IDX_W-1:0]  byte_idx_ff, byte_idx_in;
   logic [IDX_W-1:0]  end_ff, end_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] header_ff;
   logic [IDX_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]  emit_end_ff, emit_end_in;
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              slot_free;
   logic              accept;
   logic [BYTE_W-1:0] rx;
   logic              is_check;
   logic              len_bad;
   logic [IDX_W-1:0]  rd_addr_nxt;
   logic              load_out;

   logic              ram_we;
   logic              ram_re;
   logic [IDX_W-1:0]  ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   sfrc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (byte_idx_ff),
      .wr_data (rx),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && slot_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign rx           = req_ch.rx_byte;
   assign is_check     = (end_ff != '0) && (byte_idx_ff == end_ff);
   assign len_bad      = (rx == '0) || ({1'b0, rx} > MAX_LEN);
   assign rd_addr_nxt  = rd_addr_ff + IDX_W'(1);

   always_comb begin
      state_in    = state_ff;
      in_frame_in = in_frame_ff;
      byte_idx_in = byte_idx_ff;
      end_in      = end_ff;
      sum_in      = sum_ff;
      rd_addr_in  = rd_addr_ff;
      emit_end_in = emit_end_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_raddr   = rd_addr_ff;
      load_out    = 1'b0;
      rsp_kind_in = KIND_BYTE;
      rsp_data_in = '0;
      rsp_pos_in  = '0;
      rsp_last_in = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && !in_frame_ff) begin
               if (rx == header_ff) begin
                  if (byte_idx_ff != '0) begin
                     in_frame_in = 1'b1;
                     byte_idx_in = IDX_W'(2);
                     end_in      = '0;
                     sum_in      = '0;
                  end else begin
                     byte_idx_in = IDX_W'(1);
                  end
               end else begin
                  byte_idx_in = '0;
               end
            end else if (accept) begin
               ram_we = 1'b1;
               if (is_check) begin
                  in_frame_in = 1'b0;
                  byte_idx_in = '0;
                  end_in      = '0;
                  sum_in      = '0;
                  if (rx != ~sum_ff) begin
                     load_out    = 1'b1;
                     rsp_kind_in = KIND_SUM;
                  end else begin
                     // start readout from the ID byte
                     state_in    = S_LOAD;
                     ram_re      = 1'b1;
                     ram_raddr   = IDX_W'(2);
                     rd_addr_in  = IDX_W'(2);
                     emit_end_in = end_ff;
                  end
               end else if ((byte_idx_ff == IDX_W'(4)) && len_bad) begin
                  in_frame_in = 1'b0;
                  byte_idx_in = '0;
                  end_in      = '0;
                  sum_in      = '0;
                  load_out    = 1'b1;
                  rsp_kind_in = KIND_LEN;
               end else begin
                  sum_in      = sum_ff + rx;
                  byte_idx_in = byte_idx_ff + IDX_W'(1);
                  if (byte_idx_ff == IDX_W'(4)) begin
                     end_in = IDX_W'(4) + IDX_W'(rx);
                  end
               end
            end
         end
         S_LOAD: begin
            if (slot_free) begin
               load_out    = 1'b1;
               rsp_kind_in = KIND_BYTE;
               rsp_data_in = ram_rdata;
               rsp_pos_in  = POS_W'(rd_addr_ff);
               rsp_last_in = (rd_addr_nxt == emit_end_ff);
               if (rd_addr_nxt == emit_end_ff) begin
                  state_in = S_IDLE;
               end else begin
                  // fetch the next byte while this one goes out
                  ram_re     = 1'b1;
                  ram_raddr  = rd_addr_nxt;
                  rd_addr_in = rd_addr_nxt;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_frame_ff  <= 1'b0;
         byte_idx_ff  <= '0;
         end_ff       <= '0;
         sum_ff       <= '0;
         header_ff    <= HEADER_RESET;
         rd_addr_ff   <= '0;
         emit_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_frame_ff  <= in_frame_in;
         byte_idx_ff  <= byte_idx_in;
         end_ff       <= end_in;
         sum_ff       <= sum_in;
         rd_addr_ff   <= rd_addr_in;
         emit_end_ff  <= emit_end_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            header_ff <= csr_wr_data;
         end
      end
      if (load_out) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
         rsp_pos_ff  <= rsp_pos_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.kind        = rsp_kind_ff;
   assign rsp_ch.frame_data  = rsp_data_ff;
   assign rsp_ch.position    = rsp_pos_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;

   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (byte_idx_ff <= IDX_W'(1)) && (end_ff == '0) && (sum_ff == '0))
      else $error("hunting with stale frame state");

   a_idx_bounded: assert property (@(posedge clock) disable iff (reset)
      (in_frame_ff && (end_ff != '0)) |-> (byte_idx_ff <= end_ff))
      else $error("byte index ran past checksum position");

   a_readout_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> (rd_addr_ff >= IDX_W'(2)) && (rd_addr_ff < emit_end_ff))
      else $error("readout address outside frame");

   a_readout_hunting: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> !in_frame_ff)
      else $error("readout while collecting a frame");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff != KIND_BYTE)) |-> rsp_last_ff && (rsp_data_ff == '0))
      else $error("error result not a single zero beat");

endmodule

@@ verif/serial_frame_receiver_checksum_tb.sv @@
// Self-checking testbench for the serial frame receiver: random framed byte traffic, scored.
module serial_frame_receiver_checksum_tb;
   import sfrc_pkg::*;

   localparam int FRAME_BYTES     = FRAME_BYTES_DEF;
   localparam int MAX_LEN         = FRAME_BYTES - 5;
   localparam int PHASE_BYTES     = 40;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_CYCLES = 200000;

   // opening traffic, sent under the reset header value
   localparam logic [7:0] OPENING [25] = '{
      8'h00, HEADER_RESET, 8'h55,                                  // header broken by a stray byte
      HEADER_RESET, HEADER_RESET, 8'h12, 8'h34, 8'h00,             // zero length
      HEADER_RESET, HEADER_RESET, 8'h01, 8'h02, 8'h0C,             // length too large for the store
      HEADER_RESET, HEADER_RESET, HEADER_RESET, 8'h00, 8'h01, 8'hFF, // third header byte is the ID
      HEADER_RESET, HEADER_RESET, 8'h80, 8'h7F, 8'h01, 8'h00       // checksum wrong
   };

   localparam logic [7:0] HEADER_PLAN [3] = '{8'h00, 8'hA5, 8'hFF};

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data;
      logic [POS_W-1:0] pos;
      logic             last;
   } result_beat_t;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [BYTE_W-1:0] csr_wr_data;

   sfrc_req_if req_ch ();
   sfrc_rsp_if rsp_ch ();

   serial_frame_receiver_checksum i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // receiver state as predicted from the accepted bytes
   logic [7:0]   header_value;
   logic [7:0]   frame_copy [FRAME_BYTES];
   int           next_pos;
   int           check_pos;
   logic [7:0]   byte_sum;
   bit           collecting;

   logic [7:0]   pending_bytes [$];
   result_beat_t frame_results_due [$];
   result_beat_t due;

   int  bytes_queued;
   int  bytes_taken;
   int  frame_bytes_seen;
   int  error_reports_seen;
   int  mismatches;

   int  req_gap;
   int  req_left;
   bit  req_calm;
   int  rsp_wait;
   int  rsp_left;
   bit  rsp_calm;

   always #5 clock = ~clock;

   function automatic int draw_wait(inout bit calm, inout int left);
      if (left == 0) begin
         calm = ($urandom_range(0, 2) == 0);
         left = $urandom_range(8, 40);
      end
      left--;
      return calm ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic logic [7:0] rand_byte();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic drop_frame();
      collecting = 1'b0;
      next_pos   = 0;
      check_pos  = 0;
      byte_sum   = '0;
   endtask

   task automatic take_byte(input logic [7:0] b);
      result_beat_t beat;
      int           i;
      if (!collecting) begin
         if (b != header_value) begin
            next_pos = 0;
         end else if (next_pos >= 1) begin
            collecting = 1'b1;
            next_pos   = 2;
            check_pos  = 0;
            byte_sum   = '0;
         end else begin
            next_pos = 1;
         end
      end else if (check_pos != 0 && next_pos == check_pos) begin
         if (b != ~byte_sum) begin
            beat = '{kind: KIND_SUM, data: '0, pos: '0, last: 1'b1};
            frame_results_due.push_back(beat);
         end else begin
            for (i = 2; i < check_pos; i++) begin
               beat = '{kind: KIND_BYTE, data: frame_copy[i], pos: POS_W'(i),
                        last: (i + 1 == check_pos)};
               frame_results_due.push_back(beat);
            end
         end
         drop_frame();
      end else begin
         if (next_pos < FRAME_BYTES) frame_copy[next_pos] = b;
         byte_sum = byte_sum + b;
         if (next_pos == 4 && (b == 0 || b > MAX_LEN)) begin
            beat = '{kind: KIND_LEN, data: '0, pos: '0, last: 1'b1};
            frame_results_due.push_back(beat);
            drop_frame();
         end else begin
            if (next_pos == 4) check_pos = 4 + b;
            next_pos++;
            if (next_pos >= FRAME_BYTES) drop_frame();
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   // header, ID, spare, length, payload, checksum; stop after the length if it is invalid
   task automatic queue_frame(input int len, input bit sum_ok);
      logic [7:0] sum;
      logic [7:0] b;
      int         k;
      sum = '0;
      send_byte(header_value);
      send_byte(header_value);
      for (k = 0; k < 2; k++) begin
         b = rand_byte();
         send_byte(b);
         sum = sum + b;
      end
      send_byte(len[7:0]);
      sum = sum + len[7:0];
      if (len == 0 || len > MAX_LEN) return;
      for (k = 1; k < len; k++) begin
         b = rand_byte();
         send_byte(b);
         sum = sum + b;
      end
      send_byte(sum_ok ? ~sum : (~sum ^ 8'($urandom_range(1, 255))));
   endtask

   task automatic random_phase(input int target);
      int         start;
      int         pick;
      int         len;
      int         k;
      logic [7:0] b;
      start = bytes_queued;
      queue_frame(MAX_LEN, 1'b1);
      while (bytes_queued - start < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 1) ? 1 : MAX_LEN;
            else len = $urandom_range(1, MAX_LEN);
            queue_frame(len, 1'b1);
         end else if (pick < 14) begin
            queue_frame($urandom_range(1, MAX_LEN), 1'b0);
         end else if (pick == 14) begin
            queue_frame(0, 1'b1);
         end else if (pick == 15) begin
            queue_frame($urandom_range(MAX_LEN + 1, 255), 1'b1);
         end else begin
            // noise while hunting; a lone header byte first makes a broken header
            if (pick == 16) send_byte(header_value);
            for (k = 0; k < $urandom_range(1, 3); k++) begin
               b = rand_byte();
               if (b == header_value) b = b ^ 8'h01;
               send_byte(b);
            end
         end
      end
   endtask

   task automatic settle();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_ch.valid || frame_results_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // byte sender
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            take_byte(req_ch.rx_byte);
            bytes_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_ch.valid   <= 1'b1;
               req_ch.rx_byte <= pending_bytes.pop_front();
               req_gap = draw_wait(req_calm, req_left);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result sink and scoreboard
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frame_results_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d data %02h pos %0d last %0b",
                  rsp_ch.kind, rsp_ch.frame_data, rsp_ch.position, rsp_ch.last_of_run));
            end else begin
               due = frame_results_due.pop_front();
               if (rsp_ch.kind !== due.kind || rsp_ch.frame_data !== due.data ||
                   rsp_ch.position !== due.pos || rsp_ch.last_of_run !== due.last)
                  report_mismatch($sformatf(
                     "got kind %0d data %02h pos %0d last %0b, want %0d %02h %0d %0b",
                     rsp_ch.kind, rsp_ch.frame_data, rsp_ch.position, rsp_ch.last_of_run,
                     due.kind, due.data, due.pos, due.last));
               if (due.kind == KIND_BYTE) frame_bytes_seen++;
               else error_reports_seen++;
            end
            rsp_wait = draw_wait(rsp_calm, rsp_left);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      header_value   = HEADER_RESET;
      drop_frame();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      foreach (OPENING[n]) send_byte(OPENING[n]);
      random_phase(PHASE_BYTES);

      foreach (HEADER_PLAN[p]) begin
         settle();
         csr_wr_en   <= 1'b1;
         csr_wr_data <= HEADER_PLAN[p];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         header_value = HEADER_PLAN[p];
         @(negedge clock);
         random_phase(PHASE_BYTES);
      end

      settle();
      if (frame_results_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", frame_results_due.size()));
      $display("covered %0d received bytes under %0d header values", bytes_taken,
               $size(HEADER_PLAN) + 1);
      $display("checked %0d frame bytes and %0d error reports, %0d mismatches",
               frame_bytes_seen, error_reports_seen, mismatches);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #(WATCHDOG_CYCLES * 10);
      $display("watchdog expired with %0d results outstanding", frame_results_due.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
